/* hw/rtl/swmm_pkg.sv */
// Shared types, constants and digit helpers for the stopwatch display block.
package swmm_pkg;

    localparam int NUM_DIGITS  = 4;
    localparam int DIGIT_W     = 2;
    localparam int PERIOD_W    = 10;
    localparam int TIME_W      = 6;
    localparam int SEG_W       = 7;
    localparam int NUM_PHASES  = 4;
    localparam int CFG_INDEX_W = 2;

    typedef logic [PERIOD_W-1:0]    period_t;
    typedef logic [TIME_W-1:0]      time_t;
    typedef logic [SEG_W-1:0]       seg_t;
    typedef logic [NUM_DIGITS-1:0]  digit_sel_t;
    typedef logic [DIGIT_W-1:0]     digit_idx_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_SCAN   = 2'd0;
    localparam cfg_index_t REG_SWITCH = 2'd1;
    localparam cfg_index_t REG_BLINK  = 2'd2;
    localparam cfg_index_t REG_SECOND = 2'd3;

    localparam period_t SCAN_PERIOD_RST   = 10'd5;
    localparam period_t SWITCH_PERIOD_RST = 10'd20;
    localparam period_t BLINK_PERIOD_RST  = 10'd500;
    localparam period_t SECOND_PERIOD_RST = 10'd1000;

    localparam logic [6:0] TIME_LAST = 7'd59;

    localparam digit_sel_t POINT_DIGIT_SEL = 4'b1101;

    function automatic logic [3:0] tens_of(input time_t v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] ones_of(input time_t v);
        logic [3:0] t;
        time_t      base;
        t    = tens_of(v);
        base = TIME_W'({t, 3'b000}) + TIME_W'({t, 1'b0});
        return 4'(v - base);
    endfunction

    function automatic seg_t seg_of(input logic [3:0] d);
        seg_t s;
        case (d)
            4'd0:    s = 7'h3F;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5B;
            4'd3:    s = 7'h4F;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6D;
            4'd6:    s = 7'h7D;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h6F;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

/* hw/rtl/stopwatch_mmss_seven_segment_scan.sv */
// Stopwatch MM:SS with button sampling and a multiplexed seven-segment scan.
//
//   channel  direction  handshake            word
//   in       sink       in_valid/in_ready    pause_button_n, clear_button_n (one tick)
//   out      source     out_valid/out_ready  digit_select_n, segments, decimal_point,
//                                            minutes_now, seconds_now, paused_now
//   cfg      sink       cfg_valid/cfg_ready  cfg_index, cfg_data (period registers)
//
// One tick per cycle; its result shows on the next cycle from the state registers.
// A new tick is taken while a result is being drained; a stalled result blocks input.
// cfg_ready is always high; a write takes effect on the next accepted tick.
// Reset clears time, pauses, and restores the default periods.
module stopwatch_mmss_seven_segment_scan
    import swmm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       pause_button_n,
    input  logic       clear_button_n,
    output logic       out_valid,
    input  logic       out_ready,
    output digit_sel_t digit_select_n,
    output seg_t       segments,
    output logic       decimal_point,
    output time_t      minutes_now,
    output time_t      seconds_now,
    output logic       paused_now,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  period_t    cfg_data
);

    period_t    period_reg [NUM_PHASES];
    period_t    phase_reg  [NUM_PHASES];
    period_t    phase_next [NUM_PHASES];
    period_t    per_eff    [NUM_PHASES];
    logic [PERIOD_W:0] cnt_inc [NUM_PHASES];
    logic [NUM_PHASES-1:0] fire;

    time_t      minutes_reg, minutes_next;
    time_t      seconds_reg, seconds_next;
    logic       paused_reg, paused_next;
    logic       point_reg, point_next;
    logic       prev_pause_reg, prev_pause_next;
    logic       prev_clear_reg, prev_clear_next;
    digit_idx_t scan_digit_reg, scan_digit_next;
    digit_sel_t held_sel_reg, held_sel_next;
    seg_t       held_seg_reg, held_seg_next;
    logic       held_point_reg, held_point_next;
    logic       out_valid_reg, out_valid_next;

    logic       in_accept;
    logic [3:0] digit_val;
    logic [6:0] min7, sec7;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int k = 0; k < NUM_PHASES; k++)
        begin
            fire[k]       = (phase_reg[k] == '0);
            per_eff[k]    = (period_reg[k] == '0) ? PERIOD_W'(1) : period_reg[k];
            cnt_inc[k]    = {1'b0, phase_reg[k]} + (PERIOD_W+1)'(1);
            phase_next[k] = (cnt_inc[k] >= {1'b0, per_eff[k]}) ? '0
                                                               : cnt_inc[k][PERIOD_W-1:0];
        end
    end

    always_comb
    begin
        paused_next     = paused_reg;
        point_next      = point_reg;
        prev_pause_next = prev_pause_reg;
        prev_clear_next = prev_clear_reg;
        scan_digit_next = scan_digit_reg;
        held_sel_next   = held_sel_reg;
        held_seg_next   = held_seg_reg;
        held_point_next = held_point_reg;
        min7            = {1'b0, minutes_reg};
        sec7            = {1'b0, seconds_reg};
        digit_val       = '0;

        // button sample
        if (fire[REG_SWITCH])
        begin
            if (prev_pause_reg && !pause_button_n)
                paused_next = !paused_next;
            prev_pause_next = pause_button_n;
            if (prev_clear_reg && !clear_button_n)
            begin
                min7        = '0;
                sec7        = '0;
                paused_next = 1'b1;
            end
            prev_clear_next = clear_button_n;
        end

        // digit scan
        case (scan_digit_reg)
            2'd0:    digit_val = tens_of(min7[TIME_W-1:0]);
            2'd1:    digit_val = ones_of(min7[TIME_W-1:0]);
            2'd2:    digit_val = tens_of(sec7[TIME_W-1:0]);
            default: digit_val = ones_of(sec7[TIME_W-1:0]);
        endcase
        if (fire[REG_SCAN])
        begin
            held_sel_next   = ~(NUM_DIGITS'(1) << scan_digit_reg);
            held_seg_next   = seg_of(digit_val);
            held_point_next = (scan_digit_reg == DIGIT_W'(1)) && point_reg;
            scan_digit_next = scan_digit_reg + DIGIT_W'(1);
        end

        // point blink
        if (fire[REG_BLINK] && !paused_next)
            point_next = !point_reg;

        // second count
        if (fire[REG_SECOND])
        begin
            if (!paused_next)
                sec7 = sec7 + 7'd1;
            if (sec7 > TIME_LAST)
            begin
                sec7 = '0;
                min7 = min7 + 7'd1;
                if (min7 > TIME_LAST)
                    min7 = '0;
            end
            if (sec7 == TIME_LAST && min7 == TIME_LAST)
            begin
                paused_next = 1'b1;
                min7        = '0;
                sec7        = '0;
            end
        end

        minutes_next = min7[TIME_W-1:0];
        seconds_next = sec7[TIME_W-1:0];

        if (in_accept)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg[REG_SCAN]   <= SCAN_PERIOD_RST;
            period_reg[REG_SWITCH] <= SWITCH_PERIOD_RST;
            period_reg[REG_BLINK]  <= BLINK_PERIOD_RST;
            period_reg[REG_SECOND] <= SECOND_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg[cfg_index] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_PHASES; k++)
                phase_reg[k] <= '0;
            minutes_reg    <= '0;
            seconds_reg    <= '0;
            paused_reg     <= 1'b1;
            point_reg      <= 1'b0;
            prev_pause_reg <= 1'b1;
            prev_clear_reg <= 1'b1;
            scan_digit_reg <= '0;
            held_sel_reg   <= '0;
            held_seg_reg   <= '0;
            held_point_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            for (int k = 0; k < NUM_PHASES; k++)
                phase_reg[k] <= phase_next[k];
            minutes_reg    <= minutes_next;
            seconds_reg    <= seconds_next;
            paused_reg     <= paused_next;
            point_reg      <= point_next;
            prev_pause_reg <= prev_pause_next;
            prev_clear_reg <= prev_clear_next;
            scan_digit_reg <= scan_digit_next;
            held_sel_reg   <= held_sel_next;
            held_seg_reg   <= held_seg_next;
            held_point_reg <= held_point_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign out_valid      = out_valid_reg;
    assign digit_select_n = held_sel_reg;
    assign segments       = held_seg_reg;
    assign decimal_point  = held_point_reg;
    assign minutes_now    = minutes_reg;
    assign seconds_now    = seconds_reg;
    assign paused_now     = paused_reg;

endmodule

/* hw/rtl/swmm_checker.sv */
// Port-level checks for the stopwatch display block, bound to its top level.
module swmm_checker
    import swmm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input digit_sel_t digit_select_n,
    input seg_t       segments,
    input logic       decimal_point,
    input time_t      minutes_now,
    input time_t      seconds_now,
    input logic       paused_now
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(segments)
            && $stable(digit_select_n) && $stable(minutes_now) && $stable(seconds_now)
            && $stable(decimal_point) && $stable(paused_now))
        else $error("stalled result word changed");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted tick produced no result word");

    a_free_slot_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result slot");

    a_point_digit_one: assert property (@(posedge clk) disable iff (!rst_n)
        decimal_point |-> digit_select_n == POINT_DIGIT_SEL)
        else $error("decimal point lit off digit one");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> minutes_now <= TIME_W'(59) && seconds_now <= TIME_W'(59)
            && !(minutes_now == TIME_W'(59) && seconds_now == TIME_W'(59)))
        else $error("time out of range");

endmodule

bind stopwatch_mmss_seven_segment_scan swmm_checker u_swmm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .digit_select_n (digit_select_n),
    .segments       (segments),
    .decimal_point  (decimal_point),
    .minutes_now    (minutes_now),
    .seconds_now    (seconds_now),
    .paused_now     (paused_now)
);
